/* src/ewma_volatility_size_scaler_assert.svh */
// Assertion macros shared by the RTL files.
`ifndef EWMA_VOLATILITY_SIZE_SCALER_ASSERT_SVH
`define EWMA_VOLATILITY_SIZE_SCALER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define EWVS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition must never be seen outside reset
`define EWVS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define EWVS_ASSERT(lbl, clk, rst_n, prop)
`define EWVS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* src/ewvs_pkg.sv */
package ewvs_pkg;

	localparam int unsigned PRICE_W = 32;
	localparam int unsigned VOL_W   = 19;
	localparam int unsigned MULT_W  = 17;
	localparam int unsigned LAM_W   = 17;
	localparam int unsigned VAR_W   = 37;
	localparam int unsigned CFG_W   = 19;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned DIV_NW  = 62;
	localparam int unsigned DIV_DW  = 32;
	localparam int unsigned ACC_W   = 55;

	localparam int unsigned FQ_DEPTH = 4;

	localparam logic [29:0]       BPS_SCALE    = 30'd655360000;
	localparam logic [VOL_W-1:0]  RETURN_LIMIT = 19'd327680;
	localparam logic [LAM_W-1:0]  ONE_Q16      = 17'd65536;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DECAY  = 2'd0;
	localparam logic [IDX_W-1:0] REG_TARGET = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN    = 2'd2;
	localparam logic [IDX_W-1:0] REG_MAX    = 2'd3;

	localparam logic [LAM_W-1:0]  DECAY_RST  = 17'd64553;
	localparam logic [VOL_W-1:0]  TARGET_RST = 19'd5243;
	localparam logic [MULT_W-1:0] MIN_RST    = 17'd22938;
	localparam logic [MULT_W-1:0] MAX_RST    = 17'd65536;

	typedef struct packed {
		logic [LAM_W-1:0]  decay;
		logic [VOL_W-1:0]  target;
		logic [MULT_W-1:0] min_mult;
		logic [MULT_W-1:0] max_mult;
	} cfg_t;

	// word handed from front to back
	typedef struct packed {
		logic                upd;
		logic [PRICE_W-1:0]  diff;
		logic [PRICE_W-1:0]  prev;
	} job_t;

endpackage

/* src/ewvs_div.sv */
// Restoring divider, one quotient bit per cycle.
module ewvs_div #(
	parameter int unsigned NW = ewvs_pkg::DIV_NW,
	parameter int unsigned DW = ewvs_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW+1:0] trial;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (trial[DW+1]) begin
				rem_q <= shifted[DW-1:0];
			end else begin
				rem_q <= trial[DW-1:0];
			end
			quo_q <= {quo_q[NW-2:0], ~trial[DW+1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* src/ewvs_front.sv */
// Front: takes prices, tracks the last valid price, queues jobs.
`include "ewma_volatility_size_scaler_assert.svh"
module ewvs_front #(
	parameter int unsigned DEPTH = ewvs_pkg::FQ_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [ewvs_pkg::PRICE_W-1:0]  mid_px,
	input  logic                          q_pop,
	output logic                          q_empty,
	output ewvs_pkg::job_t                q_job
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ewvs_pkg::job_t            mem_q [DEPTH];
	logic [AW-1:0]             wr_q;
	logic [AW-1:0]             rd_q;
	logic [CW-1:0]             cnt_q;
	logic [ewvs_pkg::PRICE_W-1:0] prev_q;
	logic                      acc;
	logic                      deq;
	ewvs_pkg::job_t            job;

	assign full    = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign acc     = push && !full;
	assign deq     = q_pop && !q_empty;
	assign q_job   = mem_q[rd_q];

	// classify the word
	always_comb begin
		job.upd  = (mid_px != '0) && (prev_q != '0);
		job.prev = prev_q;
		job.diff = (mid_px >= prev_q) ? (mid_px - prev_q) : (prev_q - mid_px);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				if (mid_px != '0) begin
					prev_q <= mid_px;
				end
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(acc) - CW'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_q] <= job;
		end
	end

	`EWVS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`EWVS_ASSERT(a_cnt_step, clk, arst_n, (acc && !deq) |=> cnt_q == $past(cnt_q) + 1'b1)
	`EWVS_NEVER(a_upd_zero, clk, arst_n, acc && job.upd && job.prev == '0)

endmodule

/* src/ewvs_back.sv */
// Back: return, EWMA, square root, multiplier; holds the result word.
`include "ewma_volatility_size_scaler_assert.svh"
module ewvs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ewvs_pkg::cfg_t                cfg,
	input  logic                          q_empty,
	input  ewvs_pkg::job_t                q_job,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [ewvs_pkg::VOL_W-1:0]    volatility,
	output logic [ewvs_pkg::MULT_W-1:0]   size_scale
);
	localparam int unsigned VW = ewvs_pkg::VOL_W;
	localparam int unsigned NW = ewvs_pkg::DIV_NW;
	localparam int unsigned DW = ewvs_pkg::DIV_DW;
	localparam int unsigned AW = ewvs_pkg::ACC_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MUL  = 8'b00000010,
		S_DIVR = 8'b00000100,
		S_SQ   = 8'b00001000,
		S_EWMA = 8'b00010000,
		S_SQRT = 8'b00100000,
		S_DIVM = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t                 state_q;
	logic                   start_q;
	logic [31:0]            diff_q;
	logic [31:0]            prev_q;
	logic [NW-1:0]          prod_q;
	logic [VW-1:0]          ret_q;
	logic [36:0]            sq_q;
	logic [36:0]            var_q;
	logic [AW-1:0]          acc_q;
	logic [35:0]            pp_q;
	logic [2:0]             k_q;
	logic [4:0]             cnt_q;
	logic [37:0]            sv_q;
	logic [20:0]            rem_q;
	logic [VW-1:0]          root_q;
	logic [VW-1:0]          vol_q;
	logic [16:0]            mult_q;
	logic                   res_valid_q;
	logic [VW-1:0]          res_vol_q;
	logic [16:0]            res_mult_q;

	logic [NW-1:0]          div_num;
	logic [DW-1:0]          div_den;
	logic                   div_busy;
	logic                   div_done;
	logic [NW-1:0]          div_quo;
	logic [16:0]            lam;
	logic [16:0]            inv;
	logic [16:0]            mop;
	logic [18:0]            vop;
	logic [VW-1:0]          denom;
	logic [22:0]            remx;
	logic [22:0]            trial;
	logic [16:0]            m_raw;
	logic [16:0]            m_lo;
	logic                   res_we;

	// clamp lambda at one
	assign lam   = (cfg.decay > ewvs_pkg::ONE_Q16) ? ewvs_pkg::ONE_Q16 : cfg.decay;
	assign inv   = ewvs_pkg::ONE_Q16 - lam;
	assign denom = (vol_q > cfg.target) ? vol_q : cfg.target;

	// EWMA partial product operands
	always_comb begin
		unique case (k_q[1:0])
			2'd0: begin mop = lam; vop = var_q[18:0]; end
			2'd1: begin mop = lam; vop = {1'b0, var_q[36:19]}; end
			2'd2: begin mop = inv; vop = sq_q[18:0]; end
			default: begin mop = inv; vop = {1'b0, sq_q[36:19]}; end
		endcase
	end

	// square root step
	assign remx  = {rem_q, sv_q[37:36]};
	assign trial = remx - {2'b00, root_q, 2'b01};

	// divider operands
	assign div_num = state_q == S_DIVR ? prod_q
		: {{(NW - VW - 16){1'b0}}, cfg.target, 16'd0};
	assign div_den = state_q == S_DIVR ? prev_q : {{(DW - VW){1'b0}}, denom};

	ewvs_div #(.NW(NW), .DW(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	// multiplier clamps, lower first
	assign m_raw = (denom == '0) ? ewvs_pkg::ONE_Q16 : div_quo[16:0];
	assign m_lo  = (m_raw < cfg.min_mult) ? cfg.min_mult : m_raw;

	assign q_pop  = (state_q == S_IDLE) && !q_empty;
	assign res_we = (state_q == S_OUT) && (!res_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			var_q       <= '0;
			vol_q       <= '0;
			res_valid_q <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
		end else begin
			start_q <= 1'b0;
			if (res_we) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (q_job.upd) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DIVM;
							start_q <= 1'b1;
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIVR;
					start_q <= 1'b1;
				end
				S_DIVR: begin
					if (div_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_EWMA;
					k_q     <= '0;
				end
				S_EWMA: begin
					k_q <= k_q + 1'b1;
					// last partial product lands at step four
					if (k_q == 3'd5) begin
						var_q   <= acc_q[52:16];
						state_q <= S_SQRT;
						cnt_q   <= 5'd18;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						vol_q   <= trial[22] ? {root_q[VW-2:0], 1'b0}
							: {root_q[VW-2:0], 1'b1};
						state_q <= S_DIVM;
						start_q <= 1'b1;
					end
				end
				S_DIVM: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_we) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			diff_q <= q_job.diff;
			prev_q <= q_job.prev;
		end
		if (state_q == S_MUL) begin
			prod_q <= {30'd0, diff_q} * {{(NW - 30){1'b0}}, ewvs_pkg::BPS_SCALE};
		end
		if (state_q == S_DIVR && div_done) begin
			ret_q <= (div_quo > {{(NW - VW){1'b0}}, ewvs_pkg::RETURN_LIMIT})
				? ewvs_pkg::RETURN_LIMIT : div_quo[VW-1:0];
		end
		if (state_q == S_SQ) begin
			sq_q  <= 37'({19'd0, ret_q} * {19'd0, ret_q});
			acc_q <= '0;
		end
		if (state_q == S_EWMA) begin
			pp_q <= {19'd0, mop} * {17'd0, vop};
			if (k_q != '0) begin
				acc_q <= acc_q + (k_q[0] ? {19'd0, pp_q} : {pp_q, 19'd0});
			end
			if (k_q == 3'd5) begin
				sv_q   <= {1'b0, acc_q[52:16]};
				rem_q  <= '0;
				root_q <= '0;
			end
		end
		if (state_q == S_SQRT) begin
			sv_q <= {sv_q[35:0], 2'b00};
			if (trial[22]) begin
				rem_q  <= remx[20:0];
				root_q <= {root_q[VW-2:0], 1'b0};
			end else begin
				rem_q  <= trial[20:0];
				root_q <= {root_q[VW-2:0], 1'b1};
			end
		end
		if (state_q == S_DIVM && div_done) begin
			mult_q <= (m_lo > cfg.max_mult) ? cfg.max_mult : m_lo;
		end
		if (res_we) begin
			res_vol_q  <= vol_q;
			res_mult_q <= mult_q;
		end
	end

	assign empty      = !res_valid_q;
	assign volatility = res_vol_q;
	assign size_scale = res_mult_q;

	`EWVS_ASSERT(a_state_onehot, clk, arst_n, $onehot(state_q))
	`EWVS_NEVER(a_start_busy, clk, arst_n, start_q && div_busy)
	`EWVS_ASSERT(a_done_state, clk, arst_n, div_done |-> (state_q == S_DIVR || state_q == S_DIVM))
	`EWVS_ASSERT(a_pop_idle, clk, arst_n, q_pop |=> state_q != S_IDLE)

endmodule

/* src/ewma_volatility_size_scaler.sv */
// Channel   Handshake          Payload
// input     push / full        mid_px[31:0]
// result    pop / empty        volatility[18:0], size_scale[16:0]
// config    cfg_we             cfg_index[1:0], cfg_data[18:0]
//
// A price update runs in the back end through idle, product, the shared restoring
// divider for the return (start, 62 steps, done), square, EWMA, 19 square root
// steps, the divider again for the multiplier, and output. A zero or first
// price goes from idle straight to the multiplier division. The front queues up
// to four words, so push only stalls when that queue is full. arst_n clears the
// control state and loads the register defaults; a result word holds until popped.
module ewma_volatility_size_scaler #(
	parameter int unsigned FQ_DEPTH = ewvs_pkg::FQ_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [ewvs_pkg::PRICE_W-1:0]  mid_px,
	output logic                          empty,
	input  logic                          pop,
	output logic [ewvs_pkg::VOL_W-1:0]    volatility,
	output logic [ewvs_pkg::MULT_W-1:0]   size_scale,
	input  logic                          cfg_we,
	input  logic [ewvs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ewvs_pkg::CFG_W-1:0]    cfg_data
);
	ewvs_pkg::cfg_t cfg_q;
	logic           q_pop;
	logic           q_empty;
	ewvs_pkg::job_t q_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay    <= ewvs_pkg::DECAY_RST;
			cfg_q.target   <= ewvs_pkg::TARGET_RST;
			cfg_q.min_mult <= ewvs_pkg::MIN_RST;
			cfg_q.max_mult <= ewvs_pkg::MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ewvs_pkg::REG_DECAY:  cfg_q.decay    <= cfg_data[16:0];
				ewvs_pkg::REG_TARGET: cfg_q.target   <= cfg_data;
				ewvs_pkg::REG_MIN:    cfg_q.min_mult <= cfg_data[16:0];
				ewvs_pkg::REG_MAX:    cfg_q.max_mult <= cfg_data[16:0];
			endcase
		end
	end

	ewvs_front #(.DEPTH(FQ_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mid_px   (mid_px),
		.q_pop    (q_pop),
		.q_empty  (q_empty),
		.q_job    (q_job)
	);

	ewvs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_empty),
		.q_job          (q_job),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.volatility     (volatility),
		.size_scale     (size_scale)
	);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned NUM_PHASES = 8;

	// one result word as the block should present it
	typedef struct packed {
		logic [ewvs_pkg::VOL_W-1:0]  vol;
		logic [ewvs_pkg::MULT_W-1:0] mult;
	} sizing_t;

	// tracks the estimator state and holds the sizing words still owed
	class sizing_scoreboard;
		sizing_t owed[$];
		int unsigned errors;
		longint unsigned lambda_reg, target_reg, min_reg, max_reg;
		longint unsigned last_price, var_acc;
		bit seeded;

		function new();
			lambda_reg = 64'(ewvs_pkg::DECAY_RST);
			target_reg = 64'(ewvs_pkg::TARGET_RST);
			min_reg = 64'(ewvs_pkg::MIN_RST);
			max_reg = 64'(ewvs_pkg::MAX_RST);
			last_price = 0;
			var_acc = 0;
			seeded = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [ewvs_pkg::IDX_W-1:0] idx, longint unsigned val);
			case (idx)
				ewvs_pkg::REG_DECAY: lambda_reg = val & 64'h1FFFF;
				ewvs_pkg::REG_TARGET: target_reg = val & 64'h7FFFF;
				ewvs_pkg::REG_MIN: min_reg = val & 64'h1FFFF;
				ewvs_pkg::REG_MAX: max_reg = val & 64'h1FFFF;
				default: ;
			endcase
		endfunction

		// bitwise integer square root
		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_price(logic [ewvs_pkg::PRICE_W-1:0] price);
			longint unsigned p, d, ret, lam, v, den, m;
			sizing_t w;
			p = 64'(price);
			// zero price leaves the state alone; first price only seeds it
			if (p != 0) begin
				if (last_price == 0) begin
					last_price = p;
				end else begin
					d = (p >= last_price) ? p - last_price : last_price - p;
					ret = (d * 64'd655360000) / last_price;
					if (ret > 64'd327680)
						ret = 64'd327680;
					lam = (lambda_reg > 64'd65536) ? 64'd65536 : lambda_reg;
					var_acc = ((lam * var_acc + (64'd65536 - lam) * ret * ret) >> 16)
						& ((64'd1 << 37) - 1);
					last_price = p;
					seeded = 1;
				end
			end
			v = seeded ? root_floor(var_acc) : 0;
			den = (v > target_reg) ? v : target_reg;
			m = (den == 0) ? 64'd65536 : (target_reg * 64'd65536) / den;
			if (m < min_reg)
				m = min_reg;
			if (m > max_reg)
				m = max_reg;
			w.vol = v[ewvs_pkg::VOL_W-1:0];
			w.mult = m[ewvs_pkg::MULT_W-1:0];
			owed.push_back(w);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_word(logic [ewvs_pkg::VOL_W-1:0] vol, logic [ewvs_pkg::MULT_W-1:0] mult);
			sizing_t w;
			if (owed.size() == 0) begin
				report($sformatf("unexpected word vol=%0d mult=%0d", vol, mult));
				return;
			end
			w = owed.pop_front();
			if (vol !== w.vol)
				report($sformatf("volatility got %0d want %0d", vol, w.vol));
			if (mult !== w.mult)
				report($sformatf("size_scale got %0d want %0d", mult, w.mult));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [ewvs_pkg::PRICE_W-1:0] mid_px;
	logic empty;
	logic pop;
	logic [ewvs_pkg::VOL_W-1:0] volatility;
	logic [ewvs_pkg::MULT_W-1:0] size_scale;
	logic cfg_we;
	logic [ewvs_pkg::IDX_W-1:0] cfg_index;
	logic [ewvs_pkg::CFG_W-1:0] cfg_data;

	sizing_scoreboard sb;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned pop_stall_pct;
	bit hold_pop;
	longint unsigned walk_base;

	ewma_volatility_size_scaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mid_px(mid_px),
		.empty(empty),
		.pop(pop),
		.volatility(volatility),
		.size_scale(size_scale),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock and watchdog
	initial begin
		clk = 0;
		cycles = 0;
		forever begin
			#5 clk = 1;
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
			#5 clk = 0;
		end
	end

	// result side: take a word when offered, stall at random
	initial begin
		pop = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				sb.check_word(volatility, size_scale);
			pop <= !hold_pop && ($urandom_range(99) >= pop_stall_pct);
		end
	end

	task automatic send_price(logic [ewvs_pkg::PRICE_W-1:0] price);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		mid_px <= price;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_price(price);
	endtask

	// block must be idle before the registers change
	task automatic load_config(longint unsigned lam, longint unsigned tgt,
		longint unsigned lo, longint unsigned hi);
		push <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= ewvs_pkg::REG_DECAY;
		cfg_data <= lam[ewvs_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(ewvs_pkg::REG_DECAY, lam);
		cfg_index <= ewvs_pkg::REG_TARGET;
		cfg_data <= tgt[ewvs_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(ewvs_pkg::REG_TARGET, tgt);
		cfg_index <= ewvs_pkg::REG_MIN;
		cfg_data <= lo[ewvs_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(ewvs_pkg::REG_MIN, lo);
		cfg_index <= ewvs_pkg::REG_MAX;
		cfg_data <= hi[ewvs_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(ewvs_pkg::REG_MAX, hi);
		cfg_we <= 0;
	endtask

	// mostly small moves around a running price, some zeros and wild jumps
	function automatic logic [ewvs_pkg::PRICE_W-1:0] next_price();
		int unsigned r;
		longint unsigned step;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 12)
			walk_base = 64'($urandom);
		else if (r < 15)
			walk_base = 64'($urandom_range(100, 1));
		else if (r < 20 || walk_base == 0)
			walk_base = 64'($urandom_range(200000000, 1000));
		else begin
			step = 64'($urandom_range(32'((walk_base >> 11) + 2), 0));
			if ($urandom_range(1) && walk_base > step)
				walk_base -= step;
			else if (walk_base + step <= 64'hFFFFFFFF)
				walk_base += step;
		end
		if (walk_base == 0)
			walk_base = 1;
		return walk_base[ewvs_pkg::PRICE_W-1:0];
	endfunction

	initial begin
		longint unsigned lam, tgt, lo, hi;
		sb = new();
		arst_n = 0;
		push = 0;
		mid_px = 0;
		cfg_we = 0;
		cfg_index = ewvs_pkg::REG_DECAY;
		cfg_data = 0;
		hold_pop = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		walk_base = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// lambda above one freezes the variance at zero; zero target hits zero divisor
		load_config(131071, 0, 0, 131071);
		send_price(0);
		send_price(100);
		send_price(100);
		send_price(1);
		send_price(32'hFFFFFFFF);
		send_price(0);

		// defaults, then extremes of the price field
		load_config(64'(ewvs_pkg::DECAY_RST), 64'(ewvs_pkg::TARGET_RST),
			64'(ewvs_pkg::MIN_RST), 64'(ewvs_pkg::MAX_RST));
		send_price(1000000);
		send_price(1000001);
		send_price(999990);
		send_price(999990);
		send_price(0);
		send_price(2);
		send_price(32'hFFFFFFFF);
		send_price(1);
		send_price(32'h80000000);
		send_price(32'h80000001);
		send_price(32'h7FFFFFFF);
		send_price(0);

		// random phases, each with its own settings and one of four idling modes
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			lam = 64'($urandom_range(65536, 55000));
			tgt = 64'($urandom_range(327680, 1));
			lo = 64'($urandom_range(40000, 0));
			hi = 64'($urandom_range(131071, 50000));
			case (ph)
				0: lam = 0;
				1: begin tgt = 1; lo = 0; hi = 0; end
				2: begin tgt = 327680; lo = 65536; hi = 65536; end
				3: begin lo = 131071; hi = 1000; end
				4: lam = 65535;
				5: tgt = 0;
				default: ;
			endcase
			load_config(lam, tgt, lo, hi);
			case (ph % 4)
				0: begin send_idle_pct = 0; pop_stall_pct = 0; end
				1: begin send_idle_pct = 58; pop_stall_pct = 0; end
				2: begin send_idle_pct = 0; pop_stall_pct = 58; end
				default: begin send_idle_pct = 6; pop_stall_pct = 6; end
			endcase
			if (ph == 2) begin
				fork
					begin
						hold_pop = 1;
						repeat (3000) @(posedge clk);
						hold_pop = 0;
					end
				join_none
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_price(next_price());
		end

		push <= 0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
